// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_unit; depends on nothing.

package spq_pkg;

   // Default number of cells in the chain.
   localparam int DEFAULT_DEPTH = 16;

   // Field widths.
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
   localparam logic [OP_W-1:0] OP_CLR = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Command broadcast to every cell at once.
   typedef struct packed {
      logic                      enq;
      logic                      deq;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } cmd_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic                      keep;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } link_type;

endpackage

// File: rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one value and priority pair.
// Depends on spq_pkg for the command and link types.

module spq_cell (
   input  logic              clock,
   input  logic              occupied,
   input  spq_pkg::cmd_type  cmd,
   input  spq_pkg::link_type left,
   input  spq_pkg::link_type right,
   output spq_pkg::link_type own
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_in;
   logic [spq_pkg::PRIO_W-1:0]         prio_ff;
   logic [spq_pkg::PRIO_W-1:0]         prio_in;
   logic                               keep;

   // A held entry stays put on insert when its priority is not larger than the new one,
   // which places equal priorities in arrival order.
   assign keep = occupied && (prio_ff <= cmd.prio);

   // Next contents: insert point takes the request, cells behind it shift right;
   // a dequeue shifts everything left.
   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.enq && !keep) begin
         if (left.keep) begin
            value_in = cmd.value;
            prio_in  = cmd.prio;
         end else begin
            value_in = left.value;
            prio_in  = left.prio;
         end
      end else if (cmd.deq) begin
         value_in = right.value;
         prio_in  = right.prio;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign own.keep  = keep;
   assign own.value = value_ff;
   assign own.prio  = prio_ff;

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: request and response handshakes,
// entry count and the chain of spq_cell instances. Depends on spq_pkg and spq_cell.

// The queue holds up to DEPTH value and priority pairs in a row of cells kept in
// ascending priority order, so the front cell always holds the next entry to be
// served; equal priorities leave in arrival order. Every request (enqueue,
// dequeue, clear) is handled by all cells in parallel: they compare against the
// new priority at once and shift by one position in the same edge, so one
// request is taken per cycle as long as the response side keeps up. The response
// sits in an output register and appears in the cycle after its request is taken;
// a new request is accepted while that register is empty or being drained.
// Enqueue on a full queue and dequeue on an empty one leave the contents untouched
// and report their status. Occupancy reports the low 5 bits of the count.

module sorted_priority_queue_unit #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [spq_pkg::OP_W-1:0]           req_op,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_value,
   input  logic [spq_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spq_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [spq_pkg::PRIO_W-1:0]         rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]          rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [spq_pkg::STAT_W-1:0]         status_ff;
   logic [spq_pkg::STAT_W-1:0]         status_in;
   logic signed [spq_pkg::VALUE_W-1:0] out_value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] out_value_in;
   logic [spq_pkg::PRIO_W-1:0]         out_prio_ff;
   logic [spq_pkg::PRIO_W-1:0]         out_prio_in;
   logic [spq_pkg::OCC_W-1:0]          occ_ff;
   logic [spq_pkg::OCC_W-1:0]          occ_in;

   logic                               accept;
   logic                               is_empty;
   logic                               is_full;
   spq_pkg::cmd_type                   cmd;
   spq_pkg::link_type                  links [DEPTH];
   logic [DEPTH-1:0]                   occupied;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));

   // Command to the chain: only an enqueue when not full and a dequeue when not empty reach it.
   always_comb begin
      cmd.enq   = accept && (req_op == spq_pkg::OP_ENQ) && !is_full;
      cmd.deq   = accept && (req_op == spq_pkg::OP_DEQ) && !is_empty;
      cmd.value = req_value;
      cmd.prio  = req_priority_req;
   end

   // Row of cells; the front cell sees an always-keeping left neighbor and the
   // last cell refills from itself on dequeue (its slot becomes unused anyway).
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spq_pkg::link_type left_link;
      spq_pkg::link_type right_link;

      assign occupied[g] = (CNT_W'(g) < count_ff);

      if (g == 0) begin : g_front
         assign left_link.keep  = 1'b1;
         assign left_link.value = links[g].value;
         assign left_link.prio  = links[g].prio;
      end else begin : g_inner
         assign left_link = links[g-1];
      end

      if (g == DEPTH - 1) begin : g_back
         assign right_link = links[g];
      end else begin : g_mid
         assign right_link = links[g+1];
      end

      spq_cell u_cell (
         .clock    (clock),
         .occupied (occupied[g]),
         .cmd      (cmd),
         .left     (left_link),
         .right    (right_link),
         .own      (links[g])
      );
   end

   // Count and response for the accepted request.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_value_in = out_value_ff;
      out_prio_in  = out_prio_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = spq_pkg::ST_OK;
         out_value_in = '0;
         out_prio_in  = '0;
         unique case (req_op)
            spq_pkg::OP_ENQ: begin
               if (is_full) begin
                  status_in = spq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            spq_pkg::OP_DEQ: begin
               if (is_empty) begin
                  status_in = spq_pkg::ST_EMPTY;
               end else begin
                  count_in     = count_ff - CNT_W'(1);
                  out_value_in = links[0].value;
                  out_prio_in  = links[0].prio;
               end
            end
            spq_pkg::OP_CLR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         occ_in = spq_pkg::OCC_W'(count_in);
      end
   end

   // Control state with reset; response payload without.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff    <= status_in;
      out_value_ff <= out_value_in;
      out_prio_ff  <= out_prio_in;
      occ_ff       <= occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// File: tb/sv/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for sorted_priority_queue_unit: a directed stimulus table, then
// random traffic, with every response checked against an in-bench model of the sorted queue.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL.

module sorted_priority_queue_unit_tb;

   localparam int QUEUE_DEPTH     = spq_pkg::DEFAULT_DEPTH;
   localparam int RANDOM_REQUESTS = 650;
   localparam int STALL_LIMIT     = 1000;
   localparam int REPORT_LIMIT    = 10;
   localparam int DRAIN_CYCLES    = 8;

   // The op field is two bits wide; this code is not defined and must be a no-op.
   localparam logic [spq_pkg::OP_W-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [spq_pkg::STAT_W-1:0]         status;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      logic [spq_pkg::PRIO_W-1:0]         prio;
      logic [spq_pkg::OCC_W-1:0]          occ;
   } queue_result_type;

   // One line of the directed table. A row may repeat its request, stepping the value by
   // one and the priority by prio_step on each repeat.
   typedef struct packed {
      logic [spq_pkg::OP_W-1:0]           op;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      logic [spq_pkg::PRIO_W-1:0]         prio;
      logic [spq_pkg::PRIO_W-1:0]         prio_step;
      logic [7:0]                         reps;
      logic                               typed;
      queue_result_type                   want;
   } stimulus_row_type;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_ready;
   logic [spq_pkg::OP_W-1:0]           req_op           = spq_pkg::OP_ENQ;
   logic signed [spq_pkg::VALUE_W-1:0] req_value        = '0;
   logic [spq_pkg::PRIO_W-1:0]         req_priority_req = '0;
   logic                               rsp_valid;
   logic                               rsp_ready        = 1'b0;
   logic [spq_pkg::STAT_W-1:0]         rsp_status;
   logic signed [spq_pkg::VALUE_W-1:0] rsp_out_value;
   logic [spq_pkg::PRIO_W-1:0]         rsp_out_priority;
   logic [spq_pkg::OCC_W-1:0]          rsp_occupancy;

   // Model of the queue contents, kept sorted by priority with ties in arrival order.
   logic signed [spq_pkg::VALUE_W-1:0] held_value [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0]         held_prio  [QUEUE_DEPTH];
   int                                 held_count = 0;

   queue_result_type pending_responses [$];
   stimulus_row_type directed_table [$];

   int  fail_count   = 0;
   int  quiet_cycles = 0;
   int  stall_left   = 0;
   int  enq_count    = 0;
   int  deq_count    = 0;
   int  full_count   = 0;
   int  empty_count  = 0;
   int  clear_count  = 0;
   bit  sender_steady   = 1'b0;
   bit  receiver_steady = 1'b0;

   sorted_priority_queue_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the queue model and returns the response it should produce.
   function automatic queue_result_type predict_queue_response(
         input logic [spq_pkg::OP_W-1:0] op,
         input logic signed [spq_pkg::VALUE_W-1:0] value,
         input logic [spq_pkg::PRIO_W-1:0] prio);
      queue_result_type res;
      int               slot;
      res        = '0;
      res.status = spq_pkg::ST_OK;
      case (op)
         spq_pkg::OP_ENQ: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = spq_pkg::ST_FULL;
               full_count++;
            end else begin
               // Entries with a strictly larger priority move up one slot.
               slot = held_count;
               while (slot > 0 && held_prio[slot-1] > prio) begin
                  held_value[slot] = held_value[slot-1];
                  held_prio[slot]  = held_prio[slot-1];
                  slot--;
               end
               held_value[slot] = value;
               held_prio[slot]  = prio;
               held_count++;
               enq_count++;
            end
         end
         spq_pkg::OP_DEQ: begin
            if (held_count == 0) begin
               res.status = spq_pkg::ST_EMPTY;
               empty_count++;
            end else begin
               res.value = held_value[0];
               res.prio  = held_prio[0];
               for (slot = 1; slot < held_count; slot++) begin
                  held_value[slot-1] = held_value[slot];
                  held_prio[slot-1]  = held_prio[slot];
               end
               held_count--;
               deq_count++;
            end
         end
         spq_pkg::OP_CLR: begin
            held_count = 0;
            clear_count++;
         end
         default: begin
         end
      endcase
      res.occ = spq_pkg::OCC_W'(held_count);
      return res;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return 0;
      else if (pick < 85)
         return $urandom_range(3, 1);
      else if (pick < 97)
         return $urandom_range(10, 4);
      else
         return $urandom_range(30, 11);
   endfunction

   function automatic void add_row(input logic [spq_pkg::OP_W-1:0] op,
         input logic signed [spq_pkg::VALUE_W-1:0] value,
         input logic [spq_pkg::PRIO_W-1:0] prio,
         input logic [spq_pkg::PRIO_W-1:0] prio_step, input int reps, input logic typed,
         input logic [spq_pkg::STAT_W-1:0] status,
         input logic signed [spq_pkg::VALUE_W-1:0] want_value,
         input logic [spq_pkg::PRIO_W-1:0] want_prio,
         input logic [spq_pkg::OCC_W-1:0] want_occ);
      stimulus_row_type row;
      row.op          = op;
      row.value       = value;
      row.prio        = prio;
      row.prio_step   = prio_step;
      row.reps        = reps[7:0];
      row.typed       = typed;
      row.want.status = status;
      row.want.value  = want_value;
      row.want.prio   = want_prio;
      row.want.occ    = want_occ;
      directed_table.push_back(row);
   endfunction

   // Presents one request, waits for it to be taken, then records its expected response.
   task automatic issue_request(input logic [spq_pkg::OP_W-1:0] op,
         input logic signed [spq_pkg::VALUE_W-1:0] value,
         input logic [spq_pkg::PRIO_W-1:0] prio,
         input logic typed, input queue_result_type want);
      int               gap;
      queue_result_type predicted;
      gap = sender_steady ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_value        <= value;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_queue_response(op, value, prio);
      pending_responses.push_back(typed ? want : predicted);
      if ($urandom_range(59) == 0)
         sender_steady = !sender_steady;
   endtask

   // Response side: random stalls, with stretches where it is always ready.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_steady && $urandom_range(99) < 15)
            stall_left <= idle_length() + 1;
      end
      if ($urandom_range(199) == 0)
         receiver_steady <= !receiver_steady;
   end

   // Each accepted response is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : response_check
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("error: response with no request outstanding (status %0d occ %0d)",
                        rsp_status, rsp_occupancy);
            fail_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status || rsp_out_value !== want.value ||
                rsp_out_priority !== want.prio || rsp_occupancy !== want.occ) begin
               if (fail_count < REPORT_LIMIT) begin
                  $write("error: expected status %0d value %0d prio %0d occ %0d, ",
                         want.status, want.value, want.prio, want.occ);
                  $display("got status %0d value %0d prio %0d occ %0d",
                           rsp_status, rsp_out_value, rsp_out_priority, rsp_occupancy);
               end
               fail_count++;
            end
         end
      end
   end

   // Watchdog: the run ends if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("error: no request or response accepted for %0d cycles", STALL_LIMIT);
         $display("sorted_priority_queue_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      queue_result_type                   no_result;
      stimulus_row_type                   row;
      int                                 random_done;
      int                                 burst_left;
      int                                 enq_share;
      int                                 pick;
      logic [spq_pkg::OP_W-1:0]           op;
      logic [spq_pkg::PRIO_W-1:0]         prio;
      logic signed [spq_pkg::VALUE_W-1:0] value;

      no_result = '0;

      // Directed table: op, value, priority, priority step, repeats, typed, expected fields.
      add_row(spq_pkg::OP_DEQ, '0, '0, '0, 1, 1'b1, spq_pkg::ST_EMPTY, '0, '0, 5'd0);
      add_row(OP_NOP, 32'sh7FFFFFFF, 8'hFF, '0, 1, 1'b1, spq_pkg::ST_OK, '0, '0, 5'd0);
      add_row(spq_pkg::OP_ENQ, 32'sh7FFFFFFF, 8'hFF, '0, 1, 1'b1, spq_pkg::ST_OK,
              '0, '0, 5'd1);
      add_row(spq_pkg::OP_ENQ, 32'sh80000000, 8'h00, '0, 1, 1'b1, spq_pkg::ST_OK,
              '0, '0, 5'd2);
      // Ties at both priority extremes must keep arrival order.
      add_row(spq_pkg::OP_ENQ, -32'sd1, 8'hFF, '0, 1, 1'b1, spq_pkg::ST_OK, '0, '0, 5'd3);
      add_row(spq_pkg::OP_ENQ, 32'sd0, 8'h00, '0, 1, 1'b1, spq_pkg::ST_OK, '0, '0, 5'd4);
      add_row(spq_pkg::OP_DEQ, '0, '0, '0, 1, 1'b1, spq_pkg::ST_OK, 32'sh80000000, 8'h00,
              5'd3);
      // Fill to capacity: a run of equal priorities, then descending ones landing mid-queue.
      add_row(spq_pkg::OP_ENQ, 32'sh5A5A0000, 8'd9, 8'd0, 6, 1'b0, spq_pkg::ST_OK,
              '0, '0, '0);
      add_row(spq_pkg::OP_ENQ, 32'sh0000A5A5, 8'd250, 8'hF3, 7, 1'b0, spq_pkg::ST_OK,
              '0, '0, '0);
      add_row(spq_pkg::OP_ENQ, 32'sh12345678, 8'h00, '0, 1, 1'b1, spq_pkg::ST_FULL,
              '0, '0, 5'd16);
      add_row(OP_NOP, '0, '0, '0, 1, 1'b1, spq_pkg::ST_OK, '0, '0, 5'd16);
      add_row(spq_pkg::OP_DEQ, '0, '0, '0, 1, 1'b0, spq_pkg::ST_OK, '0, '0, '0);
      add_row(spq_pkg::OP_CLR, '0, '0, '0, 1, 1'b1, spq_pkg::ST_OK, '0, '0, 5'd0);
      add_row(spq_pkg::OP_DEQ, '0, '0, '0, 1, 1'b1, spq_pkg::ST_EMPTY, '0, '0, 5'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[r]) begin
         row = directed_table[r];
         for (int k = 0; k < row.reps; k++)
            issue_request(row.op, row.value + k,
                          row.prio + spq_pkg::PRIO_W'(k) * row.prio_step,
                          row.typed, row.want);
      end

      // Random traffic in bursts that lean toward filling, draining or neither, so the
      // queue keeps passing through its full and empty states.
      random_done = 0;
      burst_left  = 0;
      enq_share   = 50;
      while (random_done < RANDOM_REQUESTS) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 20);
            case ($urandom_range(2))
               0: enq_share = 75;
               1: enq_share = 25;
               default: enq_share = 50;
            endcase
         end
         burst_left--;

         pick = $urandom_range(199);
         if (pick < 4)
            op = OP_NOP;
         else if (pick < 7)
            op = spq_pkg::OP_CLR;
         else if ($urandom_range(99) < enq_share)
            op = spq_pkg::OP_ENQ;
         else
            op = spq_pkg::OP_DEQ;

         // Narrow priorities give many ties; the rest span the full range and its ends.
         pick = $urandom_range(99);
         if (pick < 50)
            prio = spq_pkg::PRIO_W'($urandom_range(7));
         else if (pick < 85)
            prio = spq_pkg::PRIO_W'($urandom_range(255));
         else
            prio = $urandom_range(1) ? 8'hFF : 8'h00;

         if ($urandom_range(9) == 0)
            value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         else
            value = $signed($urandom);

         issue_request(op, value, prio, 1'b0, no_result);
         if (op != OP_NOP)
            random_done++;
      end
      req_valid <= 1'b0;

      // Let the last responses drain, then a few quiet cycles for stray output.
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d enqueues, %0d rejected as full, %0d dequeues, %0d on empty,",
               enq_count, full_count, deq_count, empty_count);
      $display("and %0d clears, after the directed table and %0d random requests.",
               clear_count, random_done);
      if (fail_count == 0 && pending_responses.size() == 0) begin
         $display("sorted_priority_queue_unit regression: pass");
      end else begin
         $display("%0d failed checks, %0d responses missing", fail_count,
                  pending_responses.size());
         $display("sorted_priority_queue_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_tb.sv
